// ===== hdl/acpd_pkg.sv =====
// ----------------------------------------------------------------------------
// acpd_pkg
// Shared types and constants of the AC phase dimmer with fade.
// ----------------------------------------------------------------------------
package acpd_pkg;

	localparam int CHANNELS    = 3;
	localparam int GATE_W      = 3;
	localparam int LEVEL_W     = 7;
	localparam int SKIP_W      = 4;
	localparam int CHAN_W      = 2;
	localparam int FUNC_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;

	localparam logic [LEVEL_W-1:0] INIT_DELAY  = 7'd50;
	localparam logic [LEVEL_W-1:0] FULL_SCALE  = 7'd100;
	localparam logic [LEVEL_W-1:0] TICK_MAX    = 7'd127;

	localparam logic [SKIP_W-1:0]  FADE_SKIP_RST = 4'd5;
	localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 7'd10;
	localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 7'd90;

	localparam logic [FUNC_W-1:0] FUNC_ZERO_CROSS = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TICK       = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SET        = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FADE_SKIP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [CHAN_W-1:0]  channel;
		logic [LEVEL_W-1:0] light_percent;
	} in_item_t;

	typedef struct packed {
		logic [GATE_W-1:0] gates;
		logic              set_ok;
		logic              working;
	} out_item_t;

	// per-channel controls for one processed item
	typedef struct packed {
		logic               zero_cross;
		logic               tick;
		logic               set_me;
		logic [LEVEL_W-1:0] tick_nx;
		logic [LEVEL_W-1:0] target;
		logic [SKIP_W-1:0]  fade_skip;
		logic [LEVEL_W-1:0] min_level;
		logic [LEVEL_W-1:0] max_level;
	} chan_ctrl_t;

	typedef struct packed {
		logic pend_q;
		logic pend_nx;
		logic gate_nx;
	} chan_stat_t;

endpackage

// ===== hdl/acpd_chan.sv =====
// ----------------------------------------------------------------------------
// acpd_chan
// State and next-state logic of one dimmer channel: fade, clamp and firing.
// ----------------------------------------------------------------------------
module acpd_chan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  acpd_pkg::chan_ctrl_t ctrl,
	output acpd_pkg::chan_stat_t stat
);

	logic [acpd_pkg::LEVEL_W-1:0] delay_q, delay_nx;
	logic [acpd_pkg::LEVEL_W-1:0] target_q, target_nx;
	logic [acpd_pkg::SKIP_W-1:0]  skip_q, skip_nx;
	logic                         en_q, en_nx;
	logic                         pend_q, pend_nx;
	logic                         gate_q, gate_nx;
	logic [acpd_pkg::LEVEL_W-1:0] stepped;

	always_comb begin
		delay_nx  = delay_q;
		target_nx = target_q;
		skip_nx   = skip_q;
		en_nx     = en_q;
		pend_nx   = pend_q;
		gate_nx   = gate_q;
		stepped   = delay_q;
		if (delay_q < target_q) begin
			stepped = delay_q + 7'd1;
		end else if (delay_q > target_q) begin
			stepped = delay_q - 7'd1;
		end
		if (ctrl.zero_cross) begin
			if (!en_q) begin
				pend_nx = 1'b0;
			end else begin
				pend_nx = 1'b1;
				if (skip_q != '0) begin
					skip_nx = skip_q - 4'd1;
				end else begin
					skip_nx  = ctrl.fade_skip;
					delay_nx = stepped;
					if (stepped < ctrl.min_level) begin
						delay_nx = ctrl.min_level;
						en_nx    = 1'b0;
						gate_nx  = 1'b1;
						pend_nx  = 1'b0;
					end else if (stepped > ctrl.max_level) begin
						delay_nx = ctrl.max_level;
						en_nx    = 1'b0;
						gate_nx  = 1'b0;
						pend_nx  = 1'b0;
					end
				end
			end
		end else if (ctrl.tick) begin
			if (en_q && pend_q) begin
				if (ctrl.tick_nx == delay_q) begin
					gate_nx = 1'b1;
				end else if (ctrl.tick_nx > delay_q) begin
					gate_nx = 1'b0;
					pend_nx = 1'b0;
				end
			end
		end else if (ctrl.set_me) begin
			target_nx = ctrl.target;
			skip_nx   = ctrl.fade_skip;
			en_nx     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= acpd_pkg::INIT_DELAY;
			target_q <= acpd_pkg::INIT_DELAY;
			skip_q   <= '0;
			en_q     <= 1'b1;
			pend_q   <= 1'b0;
			gate_q   <= 1'b0;
		end else if (step) begin
			delay_q  <= delay_nx;
			target_q <= target_nx;
			skip_q   <= skip_nx;
			en_q     <= en_nx;
			pend_q   <= pend_nx;
			gate_q   <= gate_nx;
		end
	end

	assign stat.pend_q  = pend_q;
	assign stat.pend_nx = pend_nx;
	assign stat.gate_nx = gate_nx;

endmodule

// ===== hdl/ac_phase_dimmer_with_fade_top.sv =====
// ----------------------------------------------------------------------------
// ac_phase_dimmer_with_fade_top
// Multi-channel triac phase dimmer with slow fade toward a set level.
// ----------------------------------------------------------------------------
// Takes one item per clock while results are taken. An accepted item is held
// in the input register, is applied to the channel state as it advances and
// its result appears in the output register; a result that is not taken holds
// the advance back. The input register keeps taking items while a result waits,
// until both registers are full; throughput is set by the single state
// update per cycle. Configuration writes take effect at the write edge.
module ac_phase_dimmer_with_fade_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  acpd_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output acpd_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [acpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acpd_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                         s1_valid_q;
	acpd_pkg::in_item_t           item_s1;
	logic                         out_valid_q;
	acpd_pkg::out_item_t          out_q;
	logic                         adv;

	logic [acpd_pkg::SKIP_W-1:0]  fade_skip_q;
	logic [acpd_pkg::LEVEL_W-1:0] min_level_q;
	logic [acpd_pkg::LEVEL_W-1:0] max_level_q;
	logic [acpd_pkg::LEVEL_W-1:0] tick_q, tick_nx;
	logic [acpd_pkg::LEVEL_W-1:0] target;
	logic                         any_pend_q;
	logic                         set_ok;

	logic [acpd_pkg::GATE_W-1:0]  gate_nx;
	logic [acpd_pkg::GATE_W-1:0]  pend_nx;
	logic [acpd_pkg::GATE_W-1:0]  pend_q;

	assign adv      = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_skip_q <= acpd_pkg::FADE_SKIP_RST;
			min_level_q <= acpd_pkg::MIN_LEVEL_RST;
			max_level_q <= acpd_pkg::MAX_LEVEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				acpd_pkg::CFG_FADE_SKIP: fade_skip_q <= cfg_data[acpd_pkg::SKIP_W-1:0];
				acpd_pkg::CFG_MIN_LEVEL: min_level_q <= cfg_data;
				acpd_pkg::CFG_MAX_LEVEL: max_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign any_pend_q = |pend_q;
	assign target = (item_s1.light_percent > acpd_pkg::FULL_SCALE) ? '0 :
		acpd_pkg::FULL_SCALE - item_s1.light_percent;
	assign set_ok = (item_s1.func == acpd_pkg::FUNC_SET) &&
		({1'b0, item_s1.channel} < 3'(acpd_pkg::CHANNELS));

	always_comb begin
		tick_nx = tick_q;
		case (item_s1.func)
			acpd_pkg::FUNC_ZERO_CROSS: tick_nx = '0;
			acpd_pkg::FUNC_TICK: begin
				if (any_pend_q && tick_q != acpd_pkg::TICK_MAX) begin
					tick_nx = tick_q + 7'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (adv) begin
			tick_q <= tick_nx;
		end
	end

	for (genvar i = 0; i < acpd_pkg::GATE_W; i++) begin : g_chan
		if (i < acpd_pkg::CHANNELS) begin : g_used
			acpd_pkg::chan_ctrl_t ctrl;
			acpd_pkg::chan_stat_t stat;

			assign ctrl.zero_cross = item_s1.func == acpd_pkg::FUNC_ZERO_CROSS;
			assign ctrl.tick       = item_s1.func == acpd_pkg::FUNC_TICK;
			assign ctrl.set_me     = (item_s1.func == acpd_pkg::FUNC_SET) &&
				(item_s1.channel == acpd_pkg::CHAN_W'(i));
			assign ctrl.tick_nx    = tick_nx;
			assign ctrl.target     = target;
			assign ctrl.fade_skip  = fade_skip_q;
			assign ctrl.min_level  = min_level_q;
			assign ctrl.max_level  = max_level_q;

			acpd_chan u_chan (
				.clk    (clk),
				.arst_n (arst_n),
				.step   (adv),
				.ctrl   (ctrl),
				.stat   (stat)
			);

			assign gate_nx[i] = stat.gate_nx;
			assign pend_nx[i] = stat.pend_nx;
			assign pend_q[i]  = stat.pend_q;
		end else begin : g_unused
			assign gate_nx[i] = 1'b0;
			assign pend_nx[i] = 1'b0;
			assign pend_q[i]  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.gates   <= gate_nx;
			out_q.set_ok  <= set_ok;
			out_q.working <= |pend_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_zc_clears_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.func == acpd_pkg::FUNC_ZERO_CROSS) |=> (tick_q == '0))
		else $error("tick count not cleared by zero crossing");

	a_set_ok_only_set: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.func != acpd_pkg::FUNC_SET) |=> !out_q.set_ok)
		else $error("set_ok raised for non-set item");

	a_working_matches: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (out_q.working == any_pend_q))
		else $error("working flag disagrees with channel pending state");

	a_idle_tick_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.func == acpd_pkg::FUNC_TICK && !any_pend_q) |=> $stable(tick_q))
		else $error("tick count moved while no channel pending");
`endif

endmodule

// ===== dv/ac_phase_dimmer_with_fade_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ac_phase_dimmer_with_fade_top_tb
// Self-checking bench for the multi-channel triac phase dimmer with fade.
// ----------------------------------------------------------------------------
// A queue of items is filled per phase and fed through a valid/ready driver.
// Each accepted item is run through a cycle-free model of the dimmer and the
// predicted gates/set_ok/working are checked in order against the results.
// Phases change fade and clamp settings while the block is idle. Both sides
// insert random gaps, and the receiver holds off for long stretches twice.
// ----------------------------------------------------------------------------
module ac_phase_dimmer_with_fade_top_tb;

	localparam logic [acpd_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_ready;
	acpd_pkg::in_item_t              in_data   = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	acpd_pkg::out_item_t             out_data;
	logic                            cfg_we    = 1'b0;
	logic [acpd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [acpd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	acpd_pkg::in_item_t  items_to_send [$];
	acpd_pkg::out_item_t due_results [$];
	int                  items_made;
	int                  errors;
	int                  results_seen;

	// model state
	logic [acpd_pkg::SKIP_W-1:0]  fade_cfg;
	logic [acpd_pkg::LEVEL_W-1:0] min_cfg;
	logic [acpd_pkg::LEVEL_W-1:0] max_cfg;
	logic [acpd_pkg::LEVEL_W-1:0] lvl_now [acpd_pkg::CHANNELS];
	logic [acpd_pkg::LEVEL_W-1:0] lvl_goal [acpd_pkg::CHANNELS];
	logic [acpd_pkg::SKIP_W-1:0]  skip_left [acpd_pkg::CHANNELS];
	bit                           chan_on [acpd_pkg::CHANNELS];
	bit                           chan_armed [acpd_pkg::CHANNELS];
	bit                           gate_on [acpd_pkg::CHANNELS];
	logic [acpd_pkg::LEVEL_W-1:0] tick_now;

	// driver / receiver state
	bit                  drv_valid_nx;
	acpd_pkg::in_item_t  drv_data_nx;
	int                  drv_gap;
	bit                  drv_burst;
	bit                  rdy_nx;
	int                  rcv_gap;
	bit                  rcv_burst;
	int                  hold_left;
	int                  quiet_cycles;

	ac_phase_dimmer_with_fade_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic reset_dimmer_model();
		fade_cfg = acpd_pkg::FADE_SKIP_RST;
		min_cfg  = acpd_pkg::MIN_LEVEL_RST;
		max_cfg  = acpd_pkg::MAX_LEVEL_RST;
		for (int i = 0; i < acpd_pkg::CHANNELS; i++) begin
			lvl_now[i]    = acpd_pkg::INIT_DELAY;
			lvl_goal[i]   = acpd_pkg::INIT_DELAY;
			skip_left[i]  = '0;
			chan_on[i]    = 1'b1;
			chan_armed[i] = 1'b0;
			gate_on[i]    = 1'b0;
		end
		tick_now = '0;
	endtask

	function automatic bit any_armed();
		bit a;
		a = 1'b0;
		for (int i = 0; i < acpd_pkg::CHANNELS; i++)
			a |= chan_armed[i];
		return a;
	endfunction

	function automatic acpd_pkg::out_item_t dimmer_step(acpd_pkg::in_item_t it);
		acpd_pkg::out_item_t          res;
		logic [acpd_pkg::LEVEL_W-1:0] lit;
		res = '0;
		case (it.func)
			acpd_pkg::FUNC_ZERO_CROSS: begin
				tick_now = '0;
				for (int i = 0; i < acpd_pkg::CHANNELS; i++) begin
					if (!chan_on[i]) begin
						chan_armed[i] = 1'b0;
					end else begin
						chan_armed[i] = 1'b1;
						if (skip_left[i] != 0) begin
							skip_left[i]--;
						end else begin
							skip_left[i] = fade_cfg;
							if (lvl_now[i] < lvl_goal[i])
								lvl_now[i]++;
							else if (lvl_now[i] > lvl_goal[i])
								lvl_now[i]--;
							if (lvl_now[i] < min_cfg) begin
								lvl_now[i]    = min_cfg;
								chan_on[i]    = 1'b0;
								gate_on[i]    = 1'b1;
								chan_armed[i] = 1'b0;
							end else if (lvl_now[i] > max_cfg) begin
								lvl_now[i]    = max_cfg;
								chan_on[i]    = 1'b0;
								gate_on[i]    = 1'b0;
								chan_armed[i] = 1'b0;
							end
						end
					end
				end
			end
			acpd_pkg::FUNC_TICK: begin
				if (any_armed()) begin
					if (tick_now < acpd_pkg::TICK_MAX)
						tick_now++;
					for (int i = 0; i < acpd_pkg::CHANNELS; i++) begin
						if (chan_on[i] && chan_armed[i]) begin
							if (tick_now == lvl_now[i]) begin
								gate_on[i] = 1'b1;
							end else if (tick_now > lvl_now[i]) begin
								gate_on[i]    = 1'b0;
								chan_armed[i] = 1'b0;
							end
						end
					end
				end
			end
			acpd_pkg::FUNC_SET: begin
				if (it.channel < acpd_pkg::CHANNELS) begin
					lit = (it.light_percent > acpd_pkg::FULL_SCALE) ?
						acpd_pkg::FULL_SCALE : it.light_percent;
					lvl_goal[it.channel]  = acpd_pkg::FULL_SCALE - lit;
					skip_left[it.channel] = fade_cfg;
					chan_on[it.channel]   = 1'b1;
					res.set_ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < acpd_pkg::CHANNELS; i++)
			res.gates[i] = gate_on[i];
		res.working = any_armed();
		return res;
	endfunction

	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [acpd_pkg::CHAN_W-1:0] rand_chan();
		if ($urandom_range(0, 7) == 0)
			return 2'd3;
		return acpd_pkg::CHAN_W'($urandom_range(0, acpd_pkg::CHANNELS - 1));
	endfunction

	function automatic logic [acpd_pkg::CHAN_W-1:0] any_chan();
		return acpd_pkg::CHAN_W'($urandom);
	endfunction

	function automatic logic [acpd_pkg::FUNC_W-1:0] any_func();
		return acpd_pkg::FUNC_W'($urandom);
	endfunction

	function automatic logic [acpd_pkg::LEVEL_W-1:0] any_lit();
		return acpd_pkg::LEVEL_W'($urandom);
	endfunction

	task automatic push_item(logic [acpd_pkg::FUNC_W-1:0] f, logic [acpd_pkg::CHAN_W-1:0] ch,
			logic [acpd_pkg::LEVEL_W-1:0] lit);
		acpd_pkg::in_item_t it;
		it.func          = f;
		it.channel       = ch;
		it.light_percent = lit;
		items_to_send.push_back(it);
		items_made++;
	endtask

	task automatic write_reg(logic [acpd_pkg::CFG_IDX_W-1:0] idx,
			logic [acpd_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			acpd_pkg::CFG_FADE_SKIP: fade_cfg = val[acpd_pkg::SKIP_W-1:0];
			acpd_pkg::CFG_MIN_LEVEL: min_cfg  = val;
			acpd_pkg::CFG_MAX_LEVEL: max_cfg  = val;
			default: begin
			end
		endcase
	endtask

	task automatic set_regs(int fs, int lo, int hi);
		write_reg(acpd_pkg::CFG_FADE_SKIP, acpd_pkg::CFG_DATA_W'(fs));
		write_reg(acpd_pkg::CFG_MIN_LEVEL, acpd_pkg::CFG_DATA_W'(lo));
		write_reg(acpd_pkg::CFG_MAX_LEVEL, acpd_pkg::CFG_DATA_W'(hi));
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (items_to_send.size() != 0 || in_valid || due_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// half cycles with random content, plus noise and cut-short crossings
	task automatic gen_random(int n);
		int base;
		int r;
		int k;
		int rem;
		base = items_made;
		while (items_made - base < n) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				k = $urandom_range(0, 2);
				repeat (k) push_item(acpd_pkg::FUNC_SET, rand_chan(), any_lit());
				push_item(acpd_pkg::FUNC_ZERO_CROSS, any_chan(), any_lit());
				r = $urandom_range(0, 99);
				if (r < 45)
					k = $urandom_range(1, 30);
				else if (r < 88)
					k = $urandom_range(40, 105);
				else
					k = $urandom_range(106, 135);
				rem = n - (items_made - base);
				if (k > rem)
					k = rem;
				for (int j = 0; j < k; j++) begin
					if ($urandom_range(0, 39) == 0)
						push_item(acpd_pkg::FUNC_SET, rand_chan(), any_lit());
					push_item(acpd_pkg::FUNC_TICK, any_chan(), any_lit());
				end
			end else if (r < 85) begin
				repeat ($urandom_range(1, 5)) push_item(any_func(), any_chan(), any_lit());
			end else begin
				push_item(acpd_pkg::FUNC_ZERO_CROSS, any_chan(), any_lit());
				repeat ($urandom_range(0, 4))
					push_item(acpd_pkg::FUNC_TICK, any_chan(), any_lit());
				push_item(acpd_pkg::FUNC_ZERO_CROSS, any_chan(), any_lit());
			end
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			drv_gap  = 0;
		end else begin
			drv_valid_nx = in_valid;
			drv_data_nx  = in_data;
			if (in_valid && in_ready) begin
				due_results.push_back(dimmer_step(in_data));
				drv_valid_nx = 1'b0;
				drv_gap = pick_gap(drv_burst);
				if ($urandom_range(0, 49) == 0)
					drv_burst = !drv_burst;
			end
			if (!drv_valid_nx) begin
				if (drv_gap > 0) begin
					drv_gap--;
				end else if (items_to_send.size() != 0) begin
					drv_data_nx  = items_to_send.pop_front();
					drv_valid_nx = 1'b1;
				end
			end
			in_valid <= drv_valid_nx;
			in_data  <= drv_data_nx;
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		acpd_pkg::out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rcv_gap   = 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					if (errors < 10)
						$display("unexpected result %0d: gates %b set_ok %b working %b",
							results_seen, out_data.gates, out_data.set_ok, out_data.working);
					errors++;
				end else begin
					want = due_results.pop_front();
					if (out_data.gates !== want.gates || out_data.set_ok !== want.set_ok ||
							out_data.working !== want.working) begin
						if (errors < 10)
							$display({"mismatch at result %0d: gates exp %b got %b, ",
								"set_ok exp %b got %b, working exp %b got %b"},
								results_seen, want.gates, out_data.gates, want.set_ok,
								out_data.set_ok, want.working, out_data.working);
						errors++;
					end
				end
				if (results_seen == 300 || results_seen == 800)
					hold_left = HOLD_CYCLES;
				else
					rcv_gap = pick_gap(rcv_burst);
				if ($urandom_range(0, 49) == 0)
					rcv_burst = !rcv_burst;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy_nx = 1'b0;
			end else if (rcv_gap > 0) begin
				rcv_gap--;
				rdy_nx = 1'b0;
			end else begin
				rdy_nx = 1'b1;
			end
			out_ready <= rdy_nx;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		reset_dimmer_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset settings
		push_item(acpd_pkg::FUNC_TICK, 2'd0, 7'd0);
		push_item(FUNC_UNUSED, 2'd3, 7'd127);
		push_item(acpd_pkg::FUNC_SET, 2'd3, 7'd127);
		push_item(acpd_pkg::FUNC_SET, 2'd0, 7'd0);
		push_item(acpd_pkg::FUNC_SET, 2'd1, 7'd127);
		push_item(acpd_pkg::FUNC_SET, 2'd2, 7'd100);
		push_item(acpd_pkg::FUNC_ZERO_CROSS, 2'd0, 7'd0);
		repeat (3) push_item(acpd_pkg::FUNC_TICK, 2'd3, 7'd127);
		push_item(acpd_pkg::FUNC_SET, 2'd1, 7'd50);
		push_item(acpd_pkg::FUNC_SET, 2'd2, 7'd1);
		push_item(acpd_pkg::FUNC_ZERO_CROSS, 2'd0, 7'd0);
		repeat (3) push_item(acpd_pkg::FUNC_TICK, 2'd0, 7'd0);
		push_item(acpd_pkg::FUNC_SET, 2'd0, 7'h55);
		push_item(acpd_pkg::FUNC_SET, 2'd1, 7'h2a);
		push_item(FUNC_UNUSED, 2'd0, 7'd0);
		push_item(acpd_pkg::FUNC_ZERO_CROSS, 2'd3, 7'd127);
		repeat (2) push_item(acpd_pkg::FUNC_TICK, 2'd1, 7'd0);
		gen_random(100);
		drain();

		set_regs(0, 0, 100);
		gen_random(200);
		drain();

		// crossed limits
		set_regs(15, 100, 0);
		gen_random(120);
		drain();

		set_regs(0, 45, 55);
		gen_random(250);
		drain();

		set_regs(3, 10, 90);
		gen_random(200);
		drain();

		repeat (4) begin
			set_regs($urandom_range(0, 15), $urandom_range(0, 60), $urandom_range(40, 100));
			gen_random(80);
			drain();
		end

		repeat (10) @(negedge clk);
		if (errors == 0 && due_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
